### rtl/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int USE_W     = $clog2(MAX_TASKS + 1);

  localparam int CMD_W     = 2;
  localparam int ENTRY_W   = 4;
  localparam int TIME_W    = 16;
  localparam int REM_W     = 16;
  localparam int PRI_W     = 14;
  localparam int CNT_W     = 5;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [REM_W-1:0]  remaining;
    logic [PRI_W-1:0]  priority_lvl;
  } entry_t;

  localparam int WORD_W = $bits(entry_t);

  // scan control that goes with each word read from the table
  typedef struct packed {
    logic             start;
    logic             live;
    logic [IDX_W-1:0] idx;
    logic             entry_valid;
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } best_t;

endpackage

`default_nettype wire

### rtl/pps_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pps_item_if;
  import pps_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ENTRY_W-1:0] entry_index;
  logic [TIME_W-1:0]  arrival_value;
  logic [REM_W-1:0]   burst_value;
  logic [PRI_W-1:0]   priority_value;

  modport source (output valid, command, entry_index, arrival_value, burst_value,
                  priority_value, input ready);
  modport sink (input valid, command, entry_index, arrival_value, burst_value,
                priority_value, output ready);
endinterface

interface pps_result_if;
  import pps_pkg::*;
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] chosen_task;
  logic               idle;
  logic               task_finished;
  logic [TIME_W-1:0]  finish_time;
  logic               all_done;
  logic [TIME_W-1:0]  time_now;

  modport source (output valid, chosen_task, idle, task_finished, finish_time, all_done,
                  time_now, input ready);
  modport sink (input valid, chosen_task, idle, task_finished, finish_time, all_done,
                time_now, output ready);
endinterface

`default_nettype wire

### rtl/pps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/pps_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_scan import pps_pkg::*; (
  input  wire logic              clk,
  input  wire scan_ctl_t         ctl,
  input  wire logic [WORD_W-1:0] rd_data,
  input  wire logic [TIME_W-1:0] time_now,
  output best_t                  best
);

  entry_t cur;
  logic   take;

  assign cur = entry_t'(rd_data);

  // entries never loaded count as having no work left
  always_comb begin
    take = ctl.live && ctl.entry_valid && (cur.remaining != '0) &&
           (cur.arrival <= time_now) &&
           (!best.found || (cur.priority_lvl < best.entry.priority_lvl));
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      best.found <= 1'b0;
    end else if (take) begin
      best.found <= 1'b1;
      best.idx   <= ctl.idx;
      best.entry <= cur;
    end
  end

endmodule

`default_nettype wire

### rtl/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Load, clear, no-op items and ticks once all are done go from accept straight to S_PUSH,
// which registers the result; the next item is accepted once the state is back in S_IDLE.
// Other ticks read the table one entry per cycle through the memory read port in S_SCAN,
// then pass S_WAIT and S_WB before S_PUSH; S_PUSH waits while the output register is full.
// The output register lets the next item enter while a result waits to be taken.
// Reset (rst, synchronous) clears time, completion count, task_count and entry valid bits.

module preemptive_priority_scheduler import pps_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data,
  pps_item_if.sink              item,
  pps_result_if.source          result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]          state;
  logic [CNT_W-1:0]    task_count;
  logic [TIME_W-1:0]   current_time;
  logic [CNT_W-1:0]    completed_count;
  logic [MAX_TASKS-1:0] entry_valid;

  logic [USE_W-1:0]    in_use;
  logic [IDX_W-1:0]    last_idx;
  logic                every_done;
  logic                accept;
  logic                out_free;

  logic [IDX_W-1:0]    rd_addr;
  logic                rd_live;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_entry_valid;
  logic [WORD_W-1:0]   rd_data;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_entry;

  scan_ctl_t           ctl;
  best_t               best;
  logic [REM_W-1:0]    rem_dec;
  logic [TIME_W-1:0]   time_next;

  logic [ENTRY_W-1:0]  st_chosen;
  logic                st_idle;
  logic                st_fin;
  logic [TIME_W-1:0]   st_fin_time;

  assign in_use     = (32'(task_count) > MAX_TASKS) ? USE_W'(MAX_TASKS) : USE_W'(task_count);
  assign last_idx   = IDX_W'(in_use - USE_W'(1));
  assign every_done = 32'(completed_count) >= 32'(in_use);
  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !result.valid || result.ready;
  assign rem_dec    = best.entry.remaining - REM_W'(1);
  assign time_next  = (current_time != TIME_MAX) ? current_time + TIME_W'(1) : current_time;

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = best.idx;
    wr_entry = best.entry;
    wr_entry.remaining = rem_dec;
    if (state == S_IDLE) begin
      wr_en    = accept && (item.command == CMD_LOAD) &&
                 (32'(item.entry_index) < MAX_TASKS);
      wr_addr  = IDX_W'(item.entry_index);
      wr_entry = '{arrival: item.arrival_value, remaining: item.burst_value,
                   priority_lvl: item.priority_value};
    end else if (state == S_WB) begin
      wr_en = best.found;
    end
  end

  pps_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign ctl = '{start: accept, live: rd_live, idx: rd_idx, entry_valid: rd_entry_valid};

  pps_scan u_scan (
    .clk      (clk),
    .ctl      (ctl),
    .rd_data  (rd_data),
    .time_now (current_time),
    .best     (best)
  );

  always_ff @(posedge clk) begin
    rd_live        <= (state == S_SCAN);
    rd_idx         <= rd_addr;
    rd_entry_valid <= entry_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      task_count      <= '0;
      current_time    <= '0;
      completed_count <= '0;
      entry_valid     <= '0;
      rd_addr         <= '0;
      result.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        task_count <= cfg_data;
      end
      if (wr_en && (state == S_IDLE)) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (result.valid && result.ready && (state != S_PUSH)) begin
        result.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          rd_addr <= '0;
          if (accept) begin
            st_chosen   <= '0;
            st_idle     <= 1'b0;
            st_fin      <= 1'b0;
            st_fin_time <= '0;
            state       <= S_PUSH;
            if (item.command == CMD_CLEAR) begin
              current_time    <= '0;
              completed_count <= '0;
            end else if (item.command == CMD_TICK) begin
              if (every_done) begin
                st_idle <= 1'b1;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (rd_addr == last_idx) begin
            state <= S_WAIT;
          end else begin
            rd_addr <= rd_addr + IDX_W'(1);
          end
        end
        S_WAIT: begin
          state <= S_WB;
        end
        S_WB: begin
          current_time <= time_next;
          st_chosen    <= best.found ? ENTRY_W'(best.idx) : '0;
          st_idle      <= !best.found;
          if (best.found && (rem_dec == '0)) begin
            st_fin      <= 1'b1;
            st_fin_time <= time_next;
            if (completed_count != CNT_MAX) begin
              completed_count <= completed_count + CNT_W'(1);
            end
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          // hold the staged result until the output register frees up
          if (out_free) begin
            result.valid         <= 1'b1;
            result.chosen_task   <= st_chosen;
            result.idle          <= st_idle;
            result.task_finished <= st_fin;
            result.finish_time   <= st_fin_time;
            result.all_done      <= every_done;
            result.time_now      <= current_time;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
